// ----- design/bfc_pkg.sv -----
// Shared types, codes and constants of the brainfuck interpreter with calls.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfc_pkg;

    localparam int P_DATA_CELLS  = 32768;
    localparam int P_STACK_DEPTH = 1024;
    localparam int P_PROG_BYTES  = 4096;
    localparam int P_INPUT_DEPTH = 16;

    typedef logic [1:0] t_req;
    localparam t_req REQ_LOAD  = 2'd0;
    localparam t_req REQ_PUSH  = 2'd1;
    localparam t_req REQ_START = 2'd2;
    localparam t_req REQ_STEP  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_RUN     = 3'd0;
    localparam t_status ST_END     = 3'd1;
    localparam t_status ST_HALT    = 3'd2;
    localparam t_status ST_OVFL    = 3'd3;
    localparam t_status ST_UNDEF   = 3'd4;
    localparam t_status ST_OPEN_LB = 3'd5;
    localparam t_status ST_OPEN_RB = 3'd6;
    localparam t_status ST_QFULL   = 3'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LB     = 8'h5B;
    localparam logic [7:0] CH_RB     = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // datapath commands from the controller
    typedef struct packed {
        logic    latch;
        logic    modsub;
        logic    load;
        logic    push;
        logic    qfull;
        logic    start;
        logic    clr;
        logic    base_zero;
        logic    base_ip;
        logic    base_inc;
        logic    base_p;
        logic    k_clr;
        logic    win_cap;
        logic    rd_p;
        logic    skip0;
        logic    p_ip;
        logic    p_inc;
        logic    p_dec;
        logic    d_inc;
        logic    d_dec;
        logic    def_set;
        logic    ip_p;
        logic    ip_p1;
        logic    exec;
        logic    stat_we;
        t_status stat_val;
        logic    res_next;
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic st_run;
        logic addr_ge;
        logic q_full;
        logic clr_last;
        logic win_done;
        logic w0_zero;
        logic defh;
        logic fwd;
        logic bwd;
        logic b_zero;
        logic b_open;
        logic b_close;
        logic b_lb;
        logic b_rb;
        logic d_one;
        logic p_zero;
        logic res_last;
    } t_dstat;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } t_dec;

    // decimal digits of a byte, no leading zeros; reciprocal multiplies for /100 and /10
    function automatic t_dec dec_digits(input logic [7:0] v);
        t_dec       res;
        logic [7:0] h;
        logic [7:0] q;
        logic [7:0] t;
        logic [7:0] o;
        h = 8'((16'(v) * 16'd41) >> 12);
        q = 8'((16'(v) * 16'd205) >> 11);
        t = q - 8'(h * 8'd10);
        o = v - 8'(q * 8'd10);
        res = '0;
        if (v >= 8'd100) begin
            res.n  = 2'd3;
            res.c0 = CH_ZERO + h;
            res.c1 = CH_ZERO + t;
            res.c2 = CH_ZERO + o;
        end else if (v >= 8'd10) begin
            res.n  = 2'd2;
            res.c0 = CH_ZERO + t;
            res.c1 = CH_ZERO + o;
        end else begin
            res.n  = 2'd1;
            res.c0 = CH_ZERO + o;
        end
        return res;
    endfunction

endpackage

// ----- design/bfc_req_if.sv -----
// Request channel of the interpreter: valid/ready plus one request word.
// Stands alone; widths follow the fixed request fields.
interface bfc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [11:0] prog_addr;
    logic [7:0] data_byte;
    modport source (output valid, req_type, prog_addr, data_byte, input ready);
    modport sink   (input valid, req_type, prog_addr, data_byte, output ready);
endinterface

// ----- design/bfc_rsp_if.sv -----
// Response channel of the interpreter: valid/ready plus one result word.
// Stands alone; widths follow the fixed result fields.
interface bfc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       has_char;
    logic [7:0] out_char;
    logic       last;
    modport source (output valid, status, has_char, out_char, last, input ready);
    modport sink   (input valid, status, has_char, out_char, last, output ready);
endinterface

// ----- design/brainfuck_interpreter_with_calls.sv -----
// Top level of the brainfuck interpreter with calls: controller plus datapath.
// Depends on bfc_pkg, bfc_req_if, bfc_rsp_if, bfc_ctrl and bfc_dpath.
//
//  channel  dir  word fields                              taken when
//  i_req    in   req_type, prog_addr, data_byte           valid && ready
//  o_rsp    out  status, has_char, out_char, last         valid && ready
//
// One word at a time. A load folds the address into the store by repeated
// subtraction; a step fetches each program byte through S_WA and S_WB; bracket
// scans walk bytes through the FW or BW states, definition skips through SK.
// Start sweeps the data memory, then scans the program.
// After reset the same clearing pass runs before ready rises.
// A stalled result holds; each extra result of '#' costs one more handshake.
module brainfuck_interpreter_with_calls
    import bfc_pkg::*;
#(
    parameter int DATA_CELLS  = P_DATA_CELLS,
    parameter int STACK_DEPTH = P_STACK_DEPTH,
    parameter int PROG_BYTES  = P_PROG_BYTES,
    parameter int INPUT_DEPTH = P_INPUT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfc_req_if.sink   i_req,
    bfc_rsp_if.source o_rsp
);

    t_cmd   cmd;
    t_dstat dstat;

    bfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_ready    (i_req.ready),
        .o_valid    (o_rsp.valid),
        .i_ready    (o_rsp.ready),
        .i_stat     (dstat),
        .o_cmd      (cmd)
    );

    bfc_dpath #(
        .DATA_CELLS  (DATA_CELLS),
        .STACK_DEPTH (STACK_DEPTH),
        .PROG_BYTES  (PROG_BYTES),
        .INPUT_DEPTH (INPUT_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_prog_addr (i_req.prog_addr),
        .i_data_byte (i_req.data_byte),
        .o_stat      (dstat),
        .o_status    (o_rsp.status),
        .o_has_char  (o_rsp.has_char),
        .o_out_char  (o_rsp.out_char),
        .o_last      (o_rsp.last)
    );

endmodule

// ----- design/bfc_dpath.sv -----
// Datapath: program, data, stack and input memories, pointers and the
// command executor. Depends on bfc_pkg; driven by bfc_ctrl.
module bfc_dpath
    import bfc_pkg::*;
#(
    parameter int DATA_CELLS  = P_DATA_CELLS,
    parameter int STACK_DEPTH = P_STACK_DEPTH,
    parameter int PROG_BYTES  = P_PROG_BYTES,
    parameter int INPUT_DEPTH = P_INPUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [11:0] i_prog_addr,
    input  logic [7:0]  i_data_byte,
    output t_dstat      o_stat,
    output logic [2:0]  o_status,
    output logic        o_has_char,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    localparam int PW  = $clog2(PROG_BYTES + 1);
    localparam int PIW = $clog2(PROG_BYTES);
    localparam int AW  = PW + 3;
    localparam int DW  = $clog2(DATA_CELLS);
    localparam int SDW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int QCW = $clog2(INPUT_DEPTH + 1);
    localparam int QIW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;

    logic [7:0]     r_prog  [PROG_BYTES];
    logic [7:0]     r_data  [DATA_CELLS];
    logic [PW-1:0]  r_stack [STACK_DEPTH];
    logic [7:0]     r_queue [INPUT_DEPTH];
    logic [PW-1:0]  r_start [26];

    logic [11:0]    r_addr;
    logic [7:0]     r_byte;
    logic [7:0]     r_prd;
    logic           r_oob;
    logic [7:0]     r_cell;
    logic [PW-1:0]  r_srd;
    logic [7:0]     r_qrd;
    logic [PW-1:0]  r_ip;
    logic [PW-1:0]  r_base;
    logic [PW-1:0]  r_p;
    logic [PW:0]    r_d;
    logic [2:0]     r_k;
    logic [7:0]     r_w [5];
    logic [DW-1:0]  r_dp;
    logic [DW-1:0]  r_clr;
    logic [SDW-1:0] r_rdepth;
    logic [QIW-1:0] r_qh;
    logic [QIW-1:0] r_qt;
    logic [QCW-1:0] r_qc;
    t_status        r_status;
    logic           r_qfull;
    logic [25:0]    r_defined;
    logic [1:0]     r_nch;
    logic [1:0]     r_ri;
    logic [7:0]     r_ch [3];

    logic [AW-1:0]  rd_addr;
    logic [7:0]     pbyte;
    logic           callh;
    logic           defh;
    logic [4:0]     fn;
    logic [4:0]     def_fn;
    logic [PW-1:0]  ip1;
    t_dec           dec;

    logic [PW-1:0]  x_ip;
    logic [DW-1:0]  x_dp;
    logic           x_cell_we;
    logic [7:0]     x_cell;
    logic [SDW-1:0] x_rdepth;
    logic           x_push_we;
    t_status        x_stat;
    logic           x_qpop;
    logic [1:0]     x_nch;
    logic [7:0]     x_ch0;
    logic [7:0]     x_ch1;
    logic [7:0]     x_ch2;

    assign rd_addr = i_cmd.rd_p ? AW'(r_p) : AW'(r_base) + AW'(r_k);
    assign pbyte   = r_oob ? CH_NUL : r_prd;
    assign callh   = (r_w[0] == CH_F) && (r_w[1] >= CH_LA) && (r_w[1] <= CH_LZ) &&
                     (r_w[2] == CH_LPAR) && (r_w[3] == CH_RPAR);
    assign defh    = callh && (r_w[4] == CH_LBRACE);
    assign fn      = 5'(r_w[1] - CH_LA);
    assign def_fn  = fn;
    assign ip1     = r_ip + PW'(1);
    assign dec     = dec_digits(r_cell);

    // one command of the program, everything but the scans
    always_comb begin
        x_ip      = r_ip;
        x_dp      = r_dp;
        x_cell_we = 1'b0;
        x_cell    = r_cell;
        x_rdepth  = r_rdepth;
        x_push_we = 1'b0;
        x_stat    = r_status;
        x_qpop    = 1'b0;
        x_nch     = 2'd0;
        x_ch0     = 8'd0;
        x_ch1     = 8'd0;
        x_ch2     = 8'd0;
        if (r_w[0] == CH_NUL) begin
            x_stat = ST_END;
        end else if (callh) begin
            if (!r_defined[fn]) begin
                x_stat = ST_UNDEF;
            end else if (r_rdepth == SDW'(STACK_DEPTH)) begin
                x_stat = ST_OVFL;
            end else begin
                x_push_we = 1'b1;
                x_rdepth  = r_rdepth + SDW'(1);
                x_ip      = r_start[fn];
            end
        end else begin
            x_ip = ip1;
            case (r_w[0])
                CH_GT: begin
                    x_dp = (r_dp == DW'(DATA_CELLS - 1)) ? '0 : r_dp + DW'(1);
                end
                CH_LT: begin
                    x_dp = (r_dp == '0) ? DW'(DATA_CELLS - 1) : r_dp - DW'(1);
                end
                CH_PLUS: begin
                    x_cell_we = 1'b1;
                    x_cell    = r_cell + 8'd1;
                end
                CH_MINUS: begin
                    x_cell_we = 1'b1;
                    x_cell    = r_cell - 8'd1;
                end
                CH_DOT: begin
                    x_nch = 2'd1;
                    x_ch0 = r_cell;
                end
                CH_COMMA: begin
                    x_cell_we = 1'b1;
                    if (r_qc != '0) begin
                        x_cell = r_qrd;
                        x_qpop = 1'b1;
                    end else begin
                        x_cell = 8'hFF;
                    end
                end
                CH_RBRACE: begin
                    if (r_rdepth != '0) begin
                        x_rdepth = r_rdepth - SDW'(1);
                        x_ip     = r_srd;
                    end
                end
                CH_HASH: begin
                    x_nch = dec.n;
                    x_ch0 = dec.c0;
                    x_ch1 = dec.c1;
                    x_ch2 = dec.c2;
                end
                CH_QUEST: begin
                    x_nch = 2'd1;
                    x_ch0 = CH_NL;
                end
                CH_BANG: begin
                    x_stat = ST_HALT;
                    x_ip   = r_ip;
                end
                default: begin
                    x_ip = ip1;
                end
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prog[PIW'(r_addr)] <= r_byte;
        end
        r_prd <= r_prog[PIW'(rd_addr)];
        r_oob <= rd_addr >= AW'(PROG_BYTES);

        if (i_cmd.clr) begin
            r_data[r_clr] <= 8'd0;
        end else if (i_cmd.exec && x_cell_we) begin
            r_data[r_dp] <= x_cell;
        end
        r_cell <= r_data[r_dp];

        if (i_cmd.exec && x_push_we) begin
            r_stack[SIW'(r_rdepth)] <= r_ip + PW'(4);
        end
        r_srd <= r_stack[SIW'(r_rdepth - SDW'(1))];

        if (i_cmd.push) begin
            r_queue[r_qt] <= r_byte;
        end
        r_qrd <= r_queue[r_qh];

        if (i_cmd.def_set) begin
            r_start[def_fn] <= r_base + PW'(5);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_addr <= i_prog_addr;
            r_byte <= i_data_byte;
        end else if (i_cmd.modsub) begin
            r_addr <= r_addr - 12'(PROG_BYTES);
        end
        if (i_cmd.base_zero) begin
            r_base <= '0;
        end else if (i_cmd.base_ip) begin
            r_base <= r_ip;
        end else if (i_cmd.base_inc) begin
            r_base <= r_base + PW'(1);
        end else if (i_cmd.base_p) begin
            r_base <= r_p;
        end
        if (i_cmd.k_clr) begin
            r_k <= 3'd0;
        end else if (i_cmd.win_cap) begin
            r_w[r_k] <= pbyte;
            r_k      <= r_k + 3'd1;
        end
        if (i_cmd.skip0) begin
            r_p <= r_base + PW'(5);
        end else if (i_cmd.p_ip) begin
            r_p <= r_ip;
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + PW'(1);
        end else if (i_cmd.p_dec) begin
            r_p <= r_p - PW'(1);
        end
        if (i_cmd.skip0 || i_cmd.p_ip) begin
            r_d <= (PW+1)'(1);
        end else if (i_cmd.d_inc) begin
            r_d <= r_d + (PW+1)'(1);
        end else if (i_cmd.d_dec) begin
            r_d <= r_d - (PW+1)'(1);
        end
        if (i_cmd.exec) begin
            r_ch[0] <= x_ch0;
            r_ch[1] <= x_ch1;
            r_ch[2] <= x_ch2;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip      <= '0;
            r_dp      <= '0;
            r_clr     <= '0;
            r_rdepth  <= '0;
            r_qh      <= '0;
            r_qt      <= '0;
            r_qc      <= '0;
            r_status  <= ST_END;
            r_qfull   <= 1'b0;
            r_defined <= '0;
            r_nch     <= 2'd0;
            r_ri      <= 2'd0;
        end else begin
            if (i_cmd.latch) begin
                r_qfull <= 1'b0;
                r_nch   <= 2'd0;
                r_ri    <= 2'd0;
            end
            if (i_cmd.qfull) begin
                r_qfull <= 1'b1;
            end
            if (i_cmd.push) begin
                r_qt <= (r_qt == QIW'(INPUT_DEPTH - 1)) ? '0 : r_qt + QIW'(1);
                r_qc <= r_qc + QCW'(1);
            end
            if (i_cmd.start) begin
                r_ip      <= '0;
                r_dp      <= '0;
                r_rdepth  <= '0;
                r_defined <= '0;
                r_clr     <= '0;
            end
            if (i_cmd.clr) begin
                r_clr <= (r_clr == DW'(DATA_CELLS - 1)) ? '0 : r_clr + DW'(1);
            end
            if (i_cmd.def_set) begin
                r_defined[def_fn] <= 1'b1;
            end
            if (i_cmd.ip_p) begin
                r_ip <= r_p;
            end else if (i_cmd.ip_p1) begin
                r_ip <= r_p + PW'(1);
            end
            if (i_cmd.stat_we) begin
                r_status <= i_cmd.stat_val;
            end
            if (i_cmd.exec) begin
                r_ip     <= x_ip;
                r_dp     <= x_dp;
                r_rdepth <= x_rdepth;
                r_status <= x_stat;
                r_nch    <= x_nch;
                if (x_qpop) begin
                    r_qh <= (r_qh == QIW'(INPUT_DEPTH - 1)) ? '0 : r_qh + QIW'(1);
                    r_qc <= r_qc - QCW'(1);
                end
            end
            if (i_cmd.res_next) begin
                r_ri <= r_ri + 2'd1;
            end
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.st_run   = (r_status == ST_RUN);
        o_stat.addr_ge  = 32'(r_addr) >= 32'(PROG_BYTES);
        o_stat.q_full   = (r_qc == QCW'(INPUT_DEPTH));
        o_stat.clr_last = (r_clr == DW'(DATA_CELLS - 1));
        o_stat.win_done = (r_k == 3'd4) || ((r_k == 3'd0) && (pbyte != CH_F));
        o_stat.w0_zero  = (r_w[0] == CH_NUL);
        o_stat.defh     = defh;
        o_stat.fwd      = (r_w[0] == CH_LB) && (r_cell == 8'd0);
        o_stat.bwd      = (r_w[0] == CH_RB) && (r_cell != 8'd0);
        o_stat.b_zero   = (pbyte == CH_NUL);
        o_stat.b_open   = (pbyte == CH_LBRACE);
        o_stat.b_close  = (pbyte == CH_RBRACE);
        o_stat.b_lb     = (pbyte == CH_LB);
        o_stat.b_rb     = (pbyte == CH_RB);
        o_stat.d_one    = (r_d == (PW+1)'(1));
        o_stat.p_zero   = (r_p == '0);
        o_stat.res_last = (r_nch == 2'd0) || (r_ri == r_nch - 2'd1);
    end

    assign o_status   = r_qfull ? ST_QFULL : r_status;
    assign o_has_char = (r_nch != 2'd0);
    assign o_last     = o_stat.res_last;

    always_comb begin
        case (r_ri)
            2'd0:    o_out_char = r_ch[0];
            2'd1:    o_out_char = r_ch[1];
            2'd2:    o_out_char = r_ch[2];
            default: o_out_char = 8'd0;
        endcase
        if (r_nch == 2'd0) begin
            o_out_char = 8'd0;
        end
    end

endmodule

// ----- design/bfc_ctrl.sv -----
// Controller: sequences requests, the clearing pass, the definition scan,
// body skips and bracket scans over the datapath. Depends on bfc_pkg.
module bfc_ctrl
    import bfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_req_type,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dstat     i_stat,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_LMOD  = 5'd2;
    localparam logic [4:0] S_PUSH  = 5'd3;
    localparam logic [4:0] S_START = 5'd4;
    localparam logic [4:0] S_SC0   = 5'd5;
    localparam logic [4:0] S_STEP  = 5'd6;
    localparam logic [4:0] S_WA    = 5'd7;
    localparam logic [4:0] S_WB    = 5'd8;
    localparam logic [4:0] S_WD    = 5'd9;
    localparam logic [4:0] S_SK_A  = 5'd10;
    localparam logic [4:0] S_SK_B  = 5'd11;
    localparam logic [4:0] S_SK_D  = 5'd12;
    localparam logic [4:0] S_FW_A  = 5'd13;
    localparam logic [4:0] S_FW_B  = 5'd14;
    localparam logic [4:0] S_FW_C  = 5'd15;
    localparam logic [4:0] S_BW_A  = 5'd16;
    localparam logic [4:0] S_BW_B  = 5'd17;
    localparam logic [4:0] S_BW_C  = 5'd18;
    localparam logic [4:0] S_RESP  = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_scan;
    logic       n_scan;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_scan  = r_scan;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_scan ? S_SC0 : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_req_type)
                        REQ_LOAD:  n_state = S_LMOD;
                        REQ_PUSH:  n_state = S_PUSH;
                        REQ_START: n_state = S_START;
                        default:   n_state = S_STEP;
                    endcase
                end
            end
            S_LMOD: begin
                // fold the address into the store one subtract at a time
                if (i_stat.addr_ge) begin
                    o_cmd.modsub = 1'b1;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_PUSH: begin
                if (i_stat.q_full) begin
                    o_cmd.qfull = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                end
                n_state = S_RESP;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_scan      = 1'b1;
                n_state     = S_CLR;
            end
            S_SC0: begin
                o_cmd.base_zero = 1'b1;
                o_cmd.k_clr     = 1'b1;
                n_state         = S_WA;
            end
            S_STEP: begin
                n_scan = 1'b0;
                if (i_stat.st_run) begin
                    o_cmd.base_ip = 1'b1;
                    o_cmd.k_clr   = 1'b1;
                    n_state       = S_WA;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_WA: begin
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.win_cap = 1'b1;
                n_state = i_stat.win_done ? S_WD : S_WA;
            end
            S_WD: begin
                if (r_scan) begin
                    if (i_stat.w0_zero) begin
                        o_cmd.stat_we  = 1'b1;
                        o_cmd.stat_val = ST_RUN;
                        n_state        = S_RESP;
                    end else if (i_stat.defh) begin
                        o_cmd.def_set = 1'b1;
                        o_cmd.skip0   = 1'b1;
                        n_state       = S_SK_A;
                    end else begin
                        o_cmd.base_inc = 1'b1;
                        o_cmd.k_clr    = 1'b1;
                        n_state        = S_WA;
                    end
                end else begin
                    if (i_stat.defh) begin
                        o_cmd.skip0 = 1'b1;
                        n_state     = S_SK_A;
                    end else if (i_stat.fwd) begin
                        o_cmd.p_ip = 1'b1;
                        n_state    = S_FW_A;
                    end else if (i_stat.bwd) begin
                        o_cmd.p_ip = 1'b1;
                        n_state    = S_BW_A;
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_RESP;
                    end
                end
            end
            S_SK_A: begin
                o_cmd.rd_p = 1'b1;
                n_state    = S_SK_B;
            end
            S_SK_B: begin
                if (i_stat.b_zero) begin
                    n_state = S_SK_D;
                end else if (i_stat.b_close && i_stat.d_one) begin
                    o_cmd.p_inc = 1'b1;
                    n_state     = S_SK_D;
                end else begin
                    o_cmd.p_inc = 1'b1;
                    o_cmd.d_inc = i_stat.b_open;
                    o_cmd.d_dec = i_stat.b_close;
                    n_state     = S_SK_A;
                end
            end
            S_SK_D: begin
                if (r_scan) begin
                    o_cmd.base_p = 1'b1;
                    o_cmd.k_clr  = 1'b1;
                    n_state      = S_WA;
                end else begin
                    o_cmd.ip_p = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_FW_A: begin
                o_cmd.p_inc = 1'b1;
                n_state     = S_FW_B;
            end
            S_FW_B: begin
                o_cmd.rd_p = 1'b1;
                n_state    = S_FW_C;
            end
            S_FW_C: begin
                if (i_stat.b_zero) begin
                    o_cmd.stat_we  = 1'b1;
                    o_cmd.stat_val = ST_OPEN_LB;
                    n_state        = S_RESP;
                end else if (i_stat.b_rb && i_stat.d_one) begin
                    o_cmd.ip_p1 = 1'b1;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.d_inc = i_stat.b_lb;
                    o_cmd.d_dec = i_stat.b_rb;
                    n_state     = S_FW_A;
                end
            end
            S_BW_A: begin
                if (i_stat.p_zero) begin
                    o_cmd.stat_we  = 1'b1;
                    o_cmd.stat_val = ST_OPEN_RB;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.p_dec = 1'b1;
                    n_state     = S_BW_B;
                end
            end
            S_BW_B: begin
                o_cmd.rd_p = 1'b1;
                n_state    = S_BW_C;
            end
            S_BW_C: begin
                if (i_stat.b_lb && i_stat.d_one) begin
                    o_cmd.ip_p1 = 1'b1;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.d_inc = i_stat.b_rb;
                    o_cmd.d_dec = i_stat.b_lb;
                    n_state     = S_BW_A;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    if (i_stat.res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.res_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_scan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_RESP);

endmodule

// ----- sim/brainfuck_interpreter_with_calls_test.sv -----
// Self-checking test of brainfuck_interpreter_with_calls: directed programs, then random ones.
// Depends on bfc_pkg and the bfc_req_if / bfc_rsp_if channel interfaces of the design.
module brainfuck_interpreter_with_calls_test;
    import bfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status    st;
        logic       has;
        logic [7:0] ch;
        logic       last;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bfc_req_if req_if ();
    bfc_rsp_if rsp_if ();

    brainfuck_interpreter_with_calls u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // shadow machine state
    logic [7:0] cells [P_DATA_CELLS];
    logic [7:0] prog [P_PROG_BYTES];
    int         ret_stk [P_STACK_DEPTH];
    int         ret_depth;
    int         fn_start [26];
    bit         fn_def [26];
    logic [7:0] in_fifo [$];
    int         dptr;
    int         iptr;
    t_status    run_st;

    t_word      pending_words [$];
    int         err_cnt = 0;
    int         tx_idle = 0;
    int         rx_idle = 0;
    int         hold_cnt = 0;

    function automatic logic [7:0] pgm(int p);
        return (p < P_PROG_BYTES) ? prog[p] : CH_NUL;
    endfunction

    function automatic bit is_call(int p);
        logic [7:0] n;
        n = pgm(p + 1);
        return pgm(p) == CH_F && n >= CH_LA && n <= CH_LZ &&
               pgm(p + 2) == CH_LPAR && pgm(p + 3) == CH_RPAR;
    endfunction

    function automatic bit is_def(int p);
        return is_call(p) && pgm(p + 4) == CH_LBRACE;
    endfunction

    // p is the first body byte; returns the position after the matching brace
    function automatic int past_body(int p);
        int d;
        d = 1;
        while (d > 0 && pgm(p) != CH_NUL) begin
            if (pgm(p) == CH_LBRACE) d++;
            if (pgm(p) == CH_RBRACE) d--;
            p++;
        end
        return p;
    endfunction

    function automatic void expect_word(t_status st, logic has, logic [7:0] ch, logic last);
        pending_words.push_back('{st, has, ch, last});
    endfunction

    // execute one command; returns how many characters it emits
    function automatic int run_command(output logic [7:0] c0, output logic [7:0] c1,
                                       output logic [7:0] c2);
        int         ip;
        int         p;
        int         d;
        int         n;
        int         r;
        logic [7:0] c;
        logic [7:0] v;
        logic [7:0] outc [3];
        ip = iptr;
        c = pgm(ip);
        n = 0;
        c0 = 8'd0; c1 = 8'd0; c2 = 8'd0;
        if (c == CH_NUL) begin
            run_st = ST_END;
            return 0;
        end
        if (is_def(ip)) begin
            iptr = past_body(ip + 5);
            return 0;
        end
        if (is_call(ip)) begin
            r = int'(pgm(ip + 1) - CH_LA);
            if (!fn_def[r]) begin
                run_st = ST_UNDEF;
                return 0;
            end
            if (ret_depth >= P_STACK_DEPTH) begin
                run_st = ST_OVFL;
                return 0;
            end
            ret_stk[ret_depth] = ip + 4;
            ret_depth++;
            iptr = fn_start[r];
            return 0;
        end
        v = cells[dptr];
        case (c)
            CH_GT:    dptr = (dptr + 1) % P_DATA_CELLS;
            CH_LT:    dptr = (dptr + P_DATA_CELLS - 1) % P_DATA_CELLS;
            CH_PLUS:  cells[dptr] = v + 8'd1;
            CH_MINUS: cells[dptr] = v - 8'd1;
            CH_DOT:   begin outc[n] = v; n++; end
            CH_COMMA: cells[dptr] = (in_fifo.size() > 0) ? in_fifo.pop_front() : 8'hFF;
            CH_LB: begin
                if (v == 8'd0) begin
                    d = 1;
                    p = ip;
                    while (d > 0) begin
                        p++;
                        if (pgm(p) == CH_NUL) begin
                            run_st = ST_OPEN_LB;
                            return 0;
                        end
                        if (pgm(p) == CH_LB) d++;
                        if (pgm(p) == CH_RB) d--;
                    end
                    ip = p;
                end
            end
            CH_RB: begin
                if (v != 8'd0) begin
                    d = 1;
                    p = ip;
                    while (d > 0) begin
                        if (p == 0) begin
                            run_st = ST_OPEN_RB;
                            return 0;
                        end
                        p--;
                        if (pgm(p) == CH_RB) d++;
                        if (pgm(p) == CH_LB) d--;
                    end
                    ip = p;
                end
            end
            CH_RBRACE: begin
                if (ret_depth > 0) begin
                    ret_depth--;
                    iptr = ret_stk[ret_depth];
                    return 0;
                end
            end
            CH_HASH: begin
                if (v >= 8'd100) begin outc[n] = CH_ZERO + v / 8'd100; n++; end
                if (v >= 8'd10) begin outc[n] = CH_ZERO + (v / 8'd10) % 8'd10; n++; end
                outc[n] = CH_ZERO + v % 8'd10;
                n++;
            end
            CH_QUEST: begin outc[n] = CH_NL; n++; end
            CH_BANG: begin
                run_st = ST_HALT;
                return 0;
            end
            default: ;
        endcase
        iptr = ip + 1;
        if (n > 0) c0 = outc[0];
        if (n > 1) c1 = outc[1];
        if (n > 2) c2 = outc[2];
        return n;
    endfunction

    function automatic void predict_words(t_req rq, logic [11:0] a, logic [7:0] b);
        int         i;
        int         n;
        logic [7:0] ch [3];
        case (rq)
            REQ_LOAD: begin
                prog[a % P_PROG_BYTES] = b;
                expect_word(run_st, 1'b0, 8'd0, 1'b1);
            end
            REQ_PUSH: begin
                if (in_fifo.size() >= P_INPUT_DEPTH) begin
                    expect_word(ST_QFULL, 1'b0, 8'd0, 1'b1);
                end else begin
                    in_fifo.push_back(b);
                    expect_word(run_st, 1'b0, 8'd0, 1'b1);
                end
            end
            REQ_START: begin
                foreach (cells[j]) cells[j] = 8'd0;
                foreach (fn_def[j]) fn_def[j] = 1'b0;
                dptr = 0;
                iptr = 0;
                ret_depth = 0;
                i = 0;
                while (pgm(i) != CH_NUL) begin
                    if (is_def(i)) begin
                        fn_start[pgm(i + 1) - CH_LA] = i + 5;
                        fn_def[pgm(i + 1) - CH_LA] = 1'b1;
                        i = past_body(i + 5);
                    end else begin
                        i++;
                    end
                end
                run_st = ST_RUN;
                expect_word(run_st, 1'b0, 8'd0, 1'b1);
            end
            default: begin
                if (run_st != ST_RUN) begin
                    expect_word(run_st, 1'b0, 8'd0, 1'b1);
                end else begin
                    n = run_command(ch[0], ch[1], ch[2]);
                    if (n == 0) expect_word(run_st, 1'b0, 8'd0, 1'b1);
                    for (i = 0; i < n; i++)
                        expect_word(run_st, 1'b1, ch[i], i == n - 1);
                end
            end
        endcase
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_words.size() == 0) begin
                report("unexpected word", rsp_if.status, -1);
            end else begin
                w = pending_words.pop_front();
                if (rsp_if.status !== w.st) report("status", rsp_if.status, w.st);
                if (rsp_if.has_char !== w.has) report("has_char", rsp_if.has_char, w.has);
                if (rsp_if.out_char !== w.ch) report("out_char", rsp_if.out_char, w.ch);
                if (rsp_if.last !== w.last) report("last", rsp_if.last, w.last);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cnt--;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_word(t_req rq, logic [11:0] a, logic [7:0] b);
        while ($urandom_range(99) < tx_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rq;
        req_if.prog_addr <= a;
        req_if.data_byte <= b;
        do @(posedge i_clk); while (!req_if.ready);
        predict_words(rq, a, b);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_words.size() > 0) @(posedge i_clk);
    endtask

    task automatic load_bytes(logic [7:0] bytes [$]);
        int i;
        for (i = 0; i < bytes.size(); i++) send_word(REQ_LOAD, 12'(i), bytes[i]);
        // pad with terminators so lookahead never reads unloaded bytes
        for (i = 0; i < 4; i++) send_word(REQ_LOAD, 12'(bytes.size() + i), CH_NUL);
    endtask

    task automatic load_text(string s);
        logic [7:0] bytes [$];
        int         i;
        for (i = 0; i < s.len(); i++) bytes.push_back(s[i]);
        load_bytes(bytes);
    endtask

    task automatic run_steps(int n);
        repeat (n) send_word(REQ_STEP, 12'd0, 8'd0);
    endtask

    task automatic test_step_before_start();
        run_steps(2);
        send_word(REQ_LOAD, 12'hFFF, 8'hFF);
        send_word(REQ_LOAD, 12'h800, 8'h00);
        run_steps(1);
    endtask

    task automatic test_commands();
        load_text("fa(){++}fa()#,#.?>-#<+[-]#!");
        send_word(REQ_START, 12'd0, 8'd0);
        run_steps(20);
        drain();
    endtask

    task automatic test_input_queue();
        int i;
        send_word(REQ_PUSH, 12'd0, 8'd7);
        send_word(REQ_PUSH, 12'd0, 8'd99);
        for (i = 0; i < P_INPUT_DEPTH - 1; i++) begin
            send_word(REQ_PUSH, 12'd0, 8'($urandom_range(255)));
        end
        load_text(",#,#");
        send_word(REQ_START, 12'd0, 8'd0);
        run_steps(5);
        drain();
    endtask

    task automatic test_bracket_errors();
        load_text("+]");
        send_word(REQ_START, 12'd0, 8'd0);
        run_steps(3);
        load_text("[");
        send_word(REQ_START, 12'd0, 8'd0);
        run_steps(2);
        drain();
    endtask

    task automatic test_undefined_call();
        load_text("fz(){}fz()fb()");
        send_word(REQ_START, 12'd0, 8'd0);
        run_steps(5);
        drain();
    endtask

    task automatic random_program(bit squeeze);
        logic [7:0] bytes [$];
        logic [7:0] fn;
        int         len;
        int         k;
        string      cmds;
        cmds = "><+-.,[]#?}";
        len = $urandom_range(6, 10);
        while (bytes.size() < len) begin
            k = $urandom_range(99);
            fn = ($urandom_range(2) == 0) ? CH_LZ : 8'(CH_LA + $urandom_range(1));
            if (k < 8) begin
                bytes.push_back(CH_F); bytes.push_back(fn); bytes.push_back(CH_LPAR);
                bytes.push_back(CH_RPAR); bytes.push_back(CH_LBRACE);
                bytes.push_back(CH_PLUS); bytes.push_back(CH_HASH);
                bytes.push_back(CH_RBRACE);
            end else if (k < 16) begin
                bytes.push_back(CH_F); bytes.push_back(fn); bytes.push_back(CH_LPAR);
                bytes.push_back(CH_RPAR);
            end else if (k < 18) begin
                bytes.push_back(CH_BANG);
            end else if (k < 23) begin
                bytes.push_back(8'($urandom_range(1, 255)));
            end else begin
                bytes.push_back(cmds[$urandom_range(cmds.len() - 1)]);
            end
        end
        repeat ($urandom_range(1, 3)) send_word(REQ_PUSH, 12'd0, 8'($urandom_range(255)));
        send_word(REQ_LOAD, 12'($urandom_range(3000, 4095)), 8'($urandom_range(255)));
        load_bytes(bytes);
        send_word(REQ_START, 12'd0, 8'd0);
        // stall the result side long enough to back up the request side
        if (squeeze) hold_cnt = 400;
        run_steps(10);
        drain();
    endtask

    task automatic test_random_programs();
        tx_idle = 71;
        rx_idle = 20;
        random_program(1'b1);
        tx_idle = 0;
        rx_idle = 0;
        random_program(1'b0);
    endtask

    initial begin
        foreach (cells[j]) cells[j] = 8'd0;
        foreach (prog[j]) prog[j] = 8'd0;
        foreach (fn_def[j]) fn_def[j] = 1'b0;
        ret_depth = 0;
        dptr = 0;
        iptr = 0;
        run_st = ST_END;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_LOAD;
        req_if.prog_addr = '0;
        req_if.data_byte = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle = 20;
        rx_idle = 71;
        test_step_before_start();
        test_commands();
        test_input_queue();
        test_bracket_errors();
        test_undefined_call();
        test_random_programs();
        drain();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
